// File: rtl/core/spt_pkg.sv
// Package for the sorted point table: word types, operation and status codes,
// the per-cell control struct and the sequencer state type.
// Depends on nothing; used by spt_cell and sorted_point_table_bracket_core.
`default_nettype none

package spt_pkg;

	localparam int WORD_W = 32;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic signed [WORD_W-1:0] key;
		logic signed [WORD_W-1:0] value;
	} point_t;

	typedef struct packed {
		logic cmp_en;
		logic ins_en;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_CMP,
		SEQ_APPLY
	} seq_state_t;

endpackage

`default_nettype wire

// File: rtl/core/spt_cell.sv
// One cell of the sorted point chain: holds one point, its occupied flag and
// the result of comparing its key against the current item's key.
// Depends on spt_pkg.
`default_nettype none

module spt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spt_pkg::cell_ctrl_t ctrl,
	input  spt_pkg::point_t    new_pt,
	input  spt_pkg::point_t    left_pt,
	input  logic               left_occ,
	input  logic               left_less,
	input  logic               right_less,
	output spt_pkg::point_t    pt,
	output logic               occ,
	output logic               less,
	output logic               lower_hit,
	output logic               upper_hit
);
	import spt_pkg::*;

	point_t pt_q;
	logic   occ_q;
	logic   less_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= 1'b0;
			less_q <= 1'b0;
		end else begin
			if (ctrl.cmp_en) begin
				less_q <= occ_q && (pt_q.key < new_pt.key);
			end
			// The occupied flags form a prefix, so an insert grows it by one cell.
			if (ctrl.ins_en) begin
				occ_q <= occ_q | left_occ;
			end
		end
	end

	// Cells holding smaller keys stay put; the first other cell takes the new
	// point and every cell after it takes its left neighbor's point.
	always_ff @(posedge clk) begin
		if (ctrl.ins_en && !less_q) begin
			pt_q <= left_less ? new_pt : left_pt;
		end
	end

	assign pt        = pt_q;
	assign occ       = occ_q;
	assign less      = less_q;
	assign lower_hit = less_q & ~right_less;
	assign upper_hit = occ_q & ~less_q & left_less;

endmodule

`default_nettype wire

// File: rtl/core/sorted_point_table_bracket_core.sv
// Sorted point table with bracketing lookup. Up to CAPACITY (key, value) points
// are kept in ascending signed key order in a chain of cells, each cell holding
// one point. An insert goes ahead of older points with an equal key; an insert
// into a full table is dropped with status 1. A query returns the first point
// whose key is not less than the query key as the upper neighbor and the point
// before it as the lower neighbor, each with a found flag and zero fields when
// absent. Once accepted, each word is registered, then every cell compares its
// key in parallel, then the chain shifts (insert) or the hit cells are selected
// (query), which waits while a held result is stalled at the output. One
// word is worked on at a time; a new word is taken while the previous result
// still waits at the output. Reset empties the table at once.
// Depends on spt_pkg and spt_cell.
`default_nettype none

module sorted_point_table_bracket_core #(
	parameter int CAPACITY = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic signed [spt_pkg::WORD_W-1:0] key,
	input  logic signed [spt_pkg::WORD_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              status,
	output logic                              lower_found,
	output logic signed [spt_pkg::WORD_W-1:0] lower_key,
	output logic signed [spt_pkg::WORD_W-1:0] lower_value,
	output logic                              upper_found,
	output logic signed [spt_pkg::WORD_W-1:0] upper_key,
	output logic signed [spt_pkg::WORD_W-1:0] upper_value
);
	import spt_pkg::*;

	seq_state_t state_q;
	seq_state_t state_nxt;

	logic       op_q;
	point_t     item_q;
	cell_ctrl_t ctrl;
	logic       accept;
	logic       out_free;
	logic       apply_go;
	logic       full;

	// Chain index 0 is the virtual cell left of cell 0: always occupied and
	// smaller, so cell 0 takes the new point when it is not smaller itself.
	point_t              pt_ch   [CAPACITY+1];
	logic [CAPACITY:0]   occ_ch;
	logic [CAPACITY+1:0] less_ch;
	logic [CAPACITY-1:0] lower_hit;
	logic [CAPACITY-1:0] upper_hit;

	point_t lower_sel;
	point_t upper_sel;

	logic                     out_valid_q;
	logic                     status_q;
	logic                     lower_found_q;
	logic                     upper_found_q;
	point_t                   lower_q;
	point_t                   upper_q;

	assign out_free = !out_valid_q || !out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = occ_ch[CAPACITY];

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			SEQ_IDLE:  if (in_valid) begin
				state_nxt = SEQ_CMP;
			end
			SEQ_CMP:   state_nxt = SEQ_APPLY;
			SEQ_APPLY: if (out_free) begin
				state_nxt = SEQ_IDLE;
			end
			default:   state_nxt = SEQ_IDLE;
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		ctrl.cmp_en = 1'b0;
		apply_go    = 1'b0;
		unique case (state_q)
			SEQ_IDLE:  in_stall = 1'b0;
			SEQ_CMP:   ctrl.cmp_en = 1'b1;
			SEQ_APPLY: apply_go = out_free;
			default:   in_stall = 1'b1;
		endcase
		ctrl.ins_en = apply_go && (op_q == OP_INSERT) && !full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= operation;
			item_q.key   <= key;
			item_q.value <= value;
		end
	end

	assign pt_ch[0]          = item_q;
	assign occ_ch[0]         = 1'b1;
	assign less_ch[0]        = 1'b1;
	assign less_ch[CAPACITY+1] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_pt     (item_q),
			.left_pt    (pt_ch[i]),
			.left_occ   (occ_ch[i]),
			.left_less  (less_ch[i]),
			.right_less (less_ch[i+2]),
			.pt         (pt_ch[i+1]),
			.occ        (occ_ch[i+1]),
			.less       (less_ch[i+1]),
			.lower_hit  (lower_hit[i]),
			.upper_hit  (upper_hit[i])
		);
	end

	// At most one cell raises each hit, so an AND-OR picks its point and
	// leaves zero when there is none.
	always_comb begin
		lower_sel = '0;
		upper_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			lower_sel = lower_sel | ({$bits(point_t){lower_hit[i]}} & pt_ch[i+1]);
			upper_sel = upper_sel | ({$bits(point_t){upper_hit[i]}} & pt_ch[i+1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			if (op_q == OP_INSERT) begin
				status_q      <= full ? STATUS_FULL : STATUS_DONE;
				lower_found_q <= 1'b0;
				upper_found_q <= 1'b0;
				lower_q       <= '0;
				upper_q       <= '0;
			end else begin
				status_q      <= STATUS_DONE;
				lower_found_q <= |lower_hit;
				upper_found_q <= |upper_hit;
				lower_q       <= lower_sel;
				upper_q       <= upper_sel;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign lower_found = lower_found_q;
	assign lower_key   = lower_q.key;
	assign lower_value = lower_q.value;
	assign upper_found = upper_found_q;
	assign upper_key   = upper_q.key;
	assign upper_value = upper_q.value;

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_point_table_bracket_core: a directed table and random
// inserts and queries, checked against a sorted point list kept in the testbench or a pinned result.
// Depends on spt_pkg and the core RTL.

module tb_top;

	import spt_pkg::*;

	localparam int TABLE_DEPTH      = 16;
	localparam int DIRECTED_ROWS    = 25;
	localparam int RANDOM_WORDS     = 1100;
	localparam int LONG_HOLD_AFTER  = 400;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES     = 20;
	localparam int TIMEOUT_NS       = 3_000_000;

	localparam logic signed [WORD_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [WORD_W-1:0] KEY_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic   status;
		logic   lower_found;
		point_t lower;
		logic   upper_found;
		point_t upper;
	} bracket_t;

	// A row either pins its result to a literal or leaves it to the predictor.
	typedef struct packed {
		logic                     op;
		logic signed [WORD_W-1:0] k;
		logic signed [WORD_W-1:0] v;
		logic                     pinned;
		bracket_t                 want;
	} stim_row_t;

	typedef enum {RX_FLOW, RX_COIN, RX_HEAVY, RX_TICK} rx_mode_t;

	localparam bracket_t BRACKET_NONE = '0;
	localparam bracket_t BRACKET_FULL = '{status: STATUS_FULL, default: '0};

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     in_valid    = 1'b0;
	logic                     in_stall;
	logic                     operation   = OP_INSERT;
	logic signed [WORD_W-1:0] key         = '0;
	logic signed [WORD_W-1:0] value       = '0;
	logic                     out_valid;
	logic                     out_stall   = 1'b0;
	logic                     status;
	logic                     lower_found;
	logic signed [WORD_W-1:0] lower_key;
	logic signed [WORD_W-1:0] lower_value;
	logic                     upper_found;
	logic signed [WORD_W-1:0] upper_key;
	logic signed [WORD_W-1:0] upper_value;

	// Travel alongside the offered word so the monitor knows whether it is pinned.
	logic     row_pinned     = 1'b0;
	bracket_t pinned_bracket = '0;

	point_t   shadow_points [TABLE_DEPTH];
	int       shadow_count = 0;
	bracket_t expected_brackets [$];
	int       words_sent = 0;
	int       mismatches = 0;

	stim_row_t directed_rows [DIRECTED_ROWS];

	sorted_point_table_bracket_core #(
		.CAPACITY(TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.key(key),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.lower_found(lower_found),
		.lower_key(lower_key),
		.lower_value(lower_value),
		.upper_found(upper_found),
		.upper_key(upper_key),
		.upper_value(upper_value)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb: failure");
		$finish;
	end

	// Index of the first stored point whose key is not below k.
	function automatic int first_not_below(logic signed [WORD_W-1:0] k);
		int i;
		i = 0;
		while (i < shadow_count && $signed(shadow_points[i].key) < k)
			i++;
		return i;
	endfunction

	function automatic bracket_t apply_point_word(logic op, logic signed [WORD_W-1:0] k,
			logic signed [WORD_W-1:0] v);
		bracket_t r;
		int       pos;
		int       i;
		r = '0;
		pos = first_not_below(k);
		if (op == OP_INSERT) begin
			if (shadow_count == TABLE_DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				for (i = shadow_count; i > pos; i--)
					shadow_points[i] = shadow_points[i-1];
				shadow_points[pos] = '{key: k, value: v};
				shadow_count++;
			end
		end else begin
			if (pos > 0) begin
				r.lower_found = 1'b1;
				r.lower = shadow_points[pos-1];
			end
			if (pos < shadow_count) begin
				r.upper_found = 1'b1;
				r.upper = shadow_points[pos];
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic signed [WORD_W-1:0] want,
			input logic signed [WORD_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		bracket_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				want = apply_point_word(operation, key, value);
				if (row_pinned)
					want = pinned_bracket;
				expected_brackets.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (expected_brackets.size() == 0) begin
					$error("result word arrived with nothing expected");
					mismatches++;
				end else begin
					want = expected_brackets.pop_front();
					check_field("status", WORD_W'(want.status), WORD_W'(status));
					check_field("lower_found", WORD_W'(want.lower_found),
						WORD_W'(lower_found));
					check_field("lower_key", want.lower.key, lower_key);
					check_field("lower_value", want.lower.value, lower_value);
					check_field("upper_found", WORD_W'(want.upper_found),
						WORD_W'(upper_found));
					check_field("upper_key", want.upper.key, upper_key);
					check_field("upper_value", want.upper.value, upper_value);
				end
			end
		end
	end

	// Called at a rising edge; returns at the edge where the word was taken.
	task automatic offer_word(input logic op, input logic signed [WORD_W-1:0] k,
			input logic signed [WORD_W-1:0] v, input logic pinned, input bracket_t want);
		in_valid       <= 1'b1;
		operation      <= op;
		key            <= k;
		value          <= v;
		row_pinned     <= pinned;
		pinned_bracket <= want;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic pause_sender();
		int gap;
		// A third of the bursts run straight into the next one.
		gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int                       idx;
		int                       burst;
		int                       n;
		int                       slot;
		logic                     op;
		logic signed [WORD_W-1:0] k;
		logic signed [WORD_W-1:0] v;

		directed_rows = '{
			// Empty table: both neighbors missing.
			'{OP_QUERY,  32'sd0,           KEY_MAX,          1'b1, BRACKET_NONE},
			'{OP_QUERY,  KEY_MAX,          KEY_MIN,          1'b1, BRACKET_NONE},
			'{OP_INSERT, 32'sd0,           KEY_MAX,          1'b1, BRACKET_NONE},
			'{OP_INSERT, KEY_MIN,          KEY_MIN,          1'b1, BRACKET_NONE},
			// Equal key goes ahead of the older point.
			'{OP_INSERT, 32'sd0,           32'sd1,           1'b1, BRACKET_NONE},
			'{OP_QUERY,  32'sd1,           32'sd0,           1'b0, BRACKET_NONE},
			'{OP_QUERY,  KEY_MIN,          32'shffff_ffff,   1'b0, BRACKET_NONE},
			'{OP_QUERY,  32'sd0,           32'sd0,           1'b0, BRACKET_NONE},
			'{OP_INSERT, KEY_MAX,          32'sd0,           1'b1, BRACKET_NONE},
			'{OP_QUERY,  KEY_MAX,          32'sd0,           1'b0, BRACKET_NONE},
			'{OP_QUERY,  32'sh7fff_fffe,   32'sd0,           1'b0, BRACKET_NONE},
			'{OP_INSERT, 32'shffff_ffff,   32'sh5555_5555,   1'b1, BRACKET_NONE},
			'{OP_INSERT, 32'sd1,           32'shaaaa_aaaa,   1'b1, BRACKET_NONE},
			'{OP_INSERT, KEY_MIN,          32'sd7,           1'b1, BRACKET_NONE},
			'{OP_INSERT, KEY_MAX,          32'sh1234_5678,   1'b1, BRACKET_NONE},
			'{OP_INSERT, 32'sh0001_0000,   32'shffff_0000,   1'b1, BRACKET_NONE},
			'{OP_INSERT, 32'shffff_0000,   32'sh0001_0000,   1'b1, BRACKET_NONE},
			'{OP_INSERT, 32'sh7fff_fffe,   32'sh0000_8000,   1'b1, BRACKET_NONE},
			'{OP_INSERT, 32'sh8000_0001,   KEY_MAX,          1'b1, BRACKET_NONE},
			'{OP_INSERT, 32'sh1234_5678,   32'shdead_beef,   1'b1, BRACKET_NONE},
			'{OP_INSERT, 32'shdead_beef,   32'sh0f0f_0f0f,   1'b1, BRACKET_NONE},
			'{OP_INSERT, 32'sh0000_8000,   32'shf0f0_f0f0,   1'b1, BRACKET_NONE},
			'{OP_INSERT, 32'sd0,           32'sd0,           1'b1, BRACKET_NONE},
			// The table is full now, so this insert must be dropped.
			'{OP_INSERT, 32'sd2,           32'sd5,           1'b1, BRACKET_FULL},
			'{OP_QUERY,  32'shffff_ffff,   32'sd0,           1'b0, BRACKET_NONE}
		};

		wait (arst_n);
		@(posedge clk);

		idx = 0;
		while (idx < DIRECTED_ROWS) begin
			burst = $urandom_range(1, 8);
			while (burst > 0 && idx < DIRECTED_ROWS) begin
				offer_word(directed_rows[idx].op, directed_rows[idx].k, directed_rows[idx].v,
					directed_rows[idx].pinned, directed_rows[idx].want);
				idx++;
				burst--;
			end
			pause_sender();
		end

		// Query keys mostly land on or right next to stored keys.
		n = 0;
		while (n < RANDOM_WORDS) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && n < RANDOM_WORDS) begin
				op = 1'($urandom_range(0, 1));
				slot = (shadow_count > 0) ? $urandom_range(0, shadow_count - 1) : 0;
				case ($urandom_range(0, 9))
					0, 1, 2, 3: k = shadow_points[slot].key;
					4:          k = shadow_points[slot].key + 1;
					5:          k = shadow_points[slot].key - 1;
					6:          k = KEY_MIN;
					7:          k = KEY_MAX;
					default:    k = $urandom;
				endcase
				v = $urandom;
				offer_word(op, k, v, 1'b0, BRACKET_NONE);
				n++;
				burst--;
			end
			pause_sender();
		end
		in_valid <= 1'b0;

		while (expected_brackets.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		rx_mode_t mode;
		int       span;
		int       phase;
		bit       long_hold_done;
		long_hold_done = 1'b0;
		phase = 0;
		@(posedge clk);
		forever begin
			// One long back-pressure stretch lets the core fill up and stall its input.
			if (!long_hold_done && words_sent >= LONG_HOLD_AFTER) begin
				long_hold_done = 1'b1;
				repeat (LONG_HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(4, 60);
			repeat (span) begin
				case (mode)
					RX_FLOW:  out_stall <= 1'b0;
					RX_COIN:  out_stall <= 1'($urandom_range(0, 1));
					RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default:  out_stall <= (phase % 3 != 0);
				endcase
				phase++;
				@(posedge clk);
			end
		end
	end

endmodule
